>>> src/pgf_pkg.sv
// Shared types and constants for the pairwise gravity force block.
package pgf_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_GRAV_MANT  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_GRAV_SHIFT = 1'd1;

  localparam logic [7:0] MUL_STEPS  = 8'd33;
  localparam logic [7:0] SQRT_STEPS = 8'd33;
  localparam logic [7:0] DIV_STEPS  = 8'd128;

  typedef enum logic [3:0] {
    OP_SQX, OP_SQY, OP_SQRT, OP_R2, OP_R3, OP_GM1, OP_GM,
    OP_FXM, OP_FXD, OP_FYM, OP_FYD, OP_EDIV
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_SQRT, ST_R2, ST_R3, ST_GM1, ST_GM,
    ST_FXM, ST_FXD, ST_FYM, ST_FYD, ST_EDIV, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    ENG_MUL, ENG_SQRT, ENG_DIV
  } eng_e;

  typedef struct packed {
    logic accept;
    logic go;
    op_e  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic coin;
  } status_t;

endpackage

>>> src/pgf_ctrl.sv
// Sequencer that steps one request through the shared arithmetic engine.
module pgf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  input  pgf_pkg::status_t status_i,
  output pgf_pkg::cmd_t    cmd_o
);
  import pgf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid_i) state_d = ST_SQX;
      ST_SQX: begin
        if (status_i.coin) state_d = ST_FIN;
        else if (status_i.done) state_d = ST_SQY;
      end
      ST_SQY:  if (status_i.done) state_d = ST_SQRT;
      ST_SQRT: if (status_i.done) state_d = ST_R2;
      ST_R2:   if (status_i.done) state_d = ST_R3;
      ST_R3:   if (status_i.done) state_d = ST_GM1;
      ST_GM1:  if (status_i.done) state_d = ST_GM;
      ST_GM:   if (status_i.done) state_d = ST_FXM;
      ST_FXM:  if (status_i.done) state_d = ST_FXD;
      ST_FXD:  if (status_i.done) state_d = ST_FYM;
      ST_FYM:  if (status_i.done) state_d = ST_FYD;
      ST_FYD:  if (status_i.done) state_d = ST_EDIV;
      ST_EDIV: if (status_i.done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_SQX;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.accept    = s_axis_tvalid_i;
      end
      ST_SQX: begin
        cmd_o.go = !status_i.coin;
        cmd_o.op = OP_SQX;
      end
      ST_SQY:  begin cmd_o.go = 1'b1; cmd_o.op = OP_SQY;  end
      ST_SQRT: begin cmd_o.go = 1'b1; cmd_o.op = OP_SQRT; end
      ST_R2:   begin cmd_o.go = 1'b1; cmd_o.op = OP_R2;   end
      ST_R3:   begin cmd_o.go = 1'b1; cmd_o.op = OP_R3;   end
      ST_GM1:  begin cmd_o.go = 1'b1; cmd_o.op = OP_GM1;  end
      ST_GM:   begin cmd_o.go = 1'b1; cmd_o.op = OP_GM;   end
      ST_FXM:  begin cmd_o.go = 1'b1; cmd_o.op = OP_FXM;  end
      ST_FXD:  begin cmd_o.go = 1'b1; cmd_o.op = OP_FXD;  end
      ST_FYM:  begin cmd_o.go = 1'b1; cmd_o.op = OP_FYM;  end
      ST_FYD:  begin cmd_o.go = 1'b1; cmd_o.op = OP_FYD;  end
      ST_EDIV: begin cmd_o.go = 1'b1; cmd_o.op = OP_EDIV; end
      ST_FIN:  cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  assign m_axis_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/pgf_datapath.sv
// Datapath with a shared shift-add multiplier, square root and divider engine.
module pgf_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pgf_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic [191:0]                  in_data_i,
  input  logic                          in_clear_i,
  input  pgf_pkg::cmd_t                 cmd_i,
  output pgf_pkg::status_t              status_o,
  output logic [47:0]                   force_x_o,
  output logic [47:0]                   force_y_o,
  output logic [63:0]                   potential_sum_o,
  output logic                          coincident_o
);
  import pgf_pkg::*;

  localparam logic [63:0] Top64 = 64'h8000_0000_0000_0000;

  logic [31:0]  grav_q, grav_d;
  logic [5:0]   shift_q, shift_d;
  logic [32:0]  adx_q, adx_d, ady_q, ady_d;
  logic         negx_q, negx_d, negy_q, negy_d, coin_q, coin_d;
  logic [31:0]  m1_q, m1_d, m2_q, m2_d;
  logic [32:0]  r_q, r_d;
  logic [98:0]  r3_q, r3_d;
  logic [63:0]  k_q, k_d;
  logic [47:0]  fx_q, fx_d, fy_q, fy_d;
  logic [63:0]  sum_q, sum_d;
  logic [47:0]  ofx_q, ofx_d, ofy_q, ofy_d;
  logic [63:0]  osum_q, osum_d;
  logic         ocoin_q, ocoin_d;

  logic [127:0] a_q, a_d, acc_q, acc_d, n_q, n_d, q_q, q_d;
  logic [32:0]  b_q, b_d;
  logic [98:0]  d_q, d_d;
  logic [128:0] rem_q, rem_d;
  logic [7:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  eng_e         mode_q, mode_d;

  logic         start, done, ge;
  logic [32:0]  dx, dy;
  logic [95:0]  gsh;
  logic [63:0]  k_comb, limit;
  logic [129:0] cand, sub;
  logic [130:0] diff;

  function automatic logic [47:0] fsat(input logic [127:0] mag, input logic neg);
    logic [47:0] lim;
    logic [47:0] m;
    lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    m   = (mag > {80'b0, lim}) ? lim : mag[47:0];
    return neg ? (48'd0 - m) : m;
  endfunction

  assign start = cmd_i.go && !busy_q;
  assign done  = busy_q && (cnt_q == 8'd1);
  assign status_o.done = done;
  assign status_o.coin = coin_q;

  assign dx = {in_data_i[127], in_data_i[127:96]} - {in_data_i[31], in_data_i[31:0]};
  assign dy = {in_data_i[159], in_data_i[159:128]} - {in_data_i[63], in_data_i[63:32]};

  assign gsh    = acc_q[95:0] >> shift_q;
  assign k_comb = (|gsh[95:64]) ? '1 : gsh[63:0];
  assign limit  = sum_q ^ Top64;

  always_comb begin
    if (mode_q == ENG_SQRT) begin
      cand = {rem_q[127:0], n_q[127:126]};
      sub  = {q_q, 2'b01};
    end else begin
      cand = {rem_q, n_q[127]};
      sub  = {31'b0, d_q};
    end
    diff = {1'b0, cand} - {1'b0, sub};
    ge   = !diff[130];
  end

  always_comb begin
    grav_d = grav_q; shift_d = shift_q;
    adx_d = adx_q; ady_d = ady_q; negx_d = negx_q; negy_d = negy_q; coin_d = coin_q;
    m1_d = m1_q; m2_d = m2_q; r_d = r_q; r3_d = r3_q; k_d = k_q;
    fx_d = fx_q; fy_d = fy_q; sum_d = sum_q;
    ofx_d = ofx_q; ofy_d = ofy_q; osum_d = osum_q; ocoin_d = ocoin_q;
    a_d = a_q; b_d = b_q; acc_d = acc_q; n_d = n_q; q_d = q_q; d_d = d_q;
    rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q; mode_d = mode_q;

    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GRAV_MANT:  grav_d  = cfg_wdata_i;
        REG_GRAV_SHIFT: shift_d = cfg_wdata_i[5:0];
        default: ;
      endcase
    end

    if (cmd_i.accept) begin
      negx_d = dx[32];
      negy_d = dy[32];
      adx_d  = dx[32] ? (33'd0 - dx) : dx;
      ady_d  = dy[32] ? (33'd0 - dy) : dy;
      coin_d = (dx == 33'd0) && (dy == 33'd0);
      m1_d   = in_data_i[95:64];
      m2_d   = in_data_i[191:160];
      if (in_clear_i) sum_d = '0;
    end

    if (start) begin
      busy_d = 1'b1;
      q_d    = '0;
      rem_d  = '0;
      mode_d = ENG_MUL;
      cnt_d  = MUL_STEPS;
      case (cmd_i.op)
        OP_SQX: begin a_d = 128'(adx_q); b_d = adx_q; acc_d = '0; end
        OP_SQY: begin a_d = 128'(ady_q); b_d = ady_q; end
        OP_SQRT: begin
          mode_d = ENG_SQRT; cnt_d = SQRT_STEPS;
          n_d = {acc_q[65:0], 62'b0};
        end
        OP_R2: begin
          r_d = q_q[32:0]; a_d = 128'(q_q[32:0]); b_d = q_q[32:0]; acc_d = '0;
        end
        OP_R3:  begin a_d = acc_q; b_d = r_q; acc_d = '0; end
        OP_GM1: begin r3_d = acc_q[98:0]; a_d = 128'(grav_q); b_d = 33'(m1_q); acc_d = '0; end
        OP_GM:  begin a_d = {64'b0, acc_q[63:0]}; b_d = 33'(m2_q); acc_d = '0; end
        OP_FXM: begin k_d = k_comb; a_d = 128'(k_comb); b_d = adx_q; acc_d = '0; end
        OP_FXD, OP_FYD: begin
          mode_d = ENG_DIV; cnt_d = DIV_STEPS;
          n_d = {acc_q[95:0], 32'b0}; d_d = r3_q;
        end
        OP_FYM: begin fx_d = fsat(q_q, negx_q); a_d = 128'(k_q); b_d = ady_q; acc_d = '0; end
        OP_EDIV: begin
          fy_d = fsat(q_q, negy_q);
          mode_d = ENG_DIV; cnt_d = DIV_STEPS;
          n_d = {48'b0, k_q, 16'b0}; d_d = 99'(r_q);
        end
        default: busy_d = 1'b0;
      endcase
    end else if (busy_q) begin
      cnt_d = cnt_q - 8'd1;
      if (done) busy_d = 1'b0;
      if (mode_q == ENG_MUL) begin
        if (b_q[0]) acc_d = acc_q + a_q;
        a_d = {a_q[126:0], 1'b0};
        b_d = {1'b0, b_q[32:1]};
      end else begin
        rem_d = ge ? diff[128:0] : cand[128:0];
        q_d   = {q_q[126:0], ge};
        n_d   = (mode_q == ENG_SQRT) ? {n_q[125:0], 2'b0} : {n_q[126:0], 1'b0};
      end
    end

    if (cmd_i.load_out) begin
      ocoin_d = coin_q;
      if (coin_q) begin
        ofx_d  = '0;
        ofy_d  = '0;
        osum_d = sum_q;
      end else begin
        ofx_d = fx_q;
        ofy_d = fy_q;
        if ((|q_q[127:64]) || (q_q[63:0] > limit)) sum_d = Top64;
        else sum_d = sum_q - q_q[63:0];
        osum_d = sum_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= '0;
      shift_q <= '0;
      sum_q   <= '0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      mode_q  <= ENG_MUL;
      coin_q  <= 1'b0;
    end else begin
      grav_q  <= grav_d;
      shift_q <= shift_d;
      sum_q   <= sum_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
      coin_q  <= coin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q <= adx_d; ady_q <= ady_d; negx_q <= negx_d; negy_q <= negy_d;
    m1_q <= m1_d; m2_q <= m2_d; r_q <= r_d; r3_q <= r3_d; k_q <= k_d;
    fx_q <= fx_d; fy_q <= fy_d;
    ofx_q <= ofx_d; ofy_q <= ofy_d; osum_q <= osum_d; ocoin_q <= ocoin_d;
    a_q <= a_d; b_q <= b_d; acc_q <= acc_d; n_q <= n_d; q_q <= q_d;
    d_q <= d_d; rem_q <= rem_d;
  end

  assign force_x_o       = ofx_q;
  assign force_y_o       = ofy_q;
  assign potential_sum_o = osum_q;
  assign coincident_o    = ocoin_q;

endmodule

>>> src/pairwise_gravity_force.sv
// Top level of the pairwise gravity force block.
//
//  channel | direction | tdata (low bit first)                          | tuser
//  s_axis  | in        | first_x, first_y, first_mass, second_x,        | clear_sum
//          |           | second_y, second_mass                          |
//  m_axis  | out       | force_x, force_y, potential_sum                | coincident
//  cfg     | in        | index 0 gravity mantissa, index 1 grav_shift   | -
//
// A request runs eight multiplies, a square root and three divides one after another on
// the single shared shift-add and restoring divide engine, after the accept and before the
// result write; coincident points go straight from the accept to the result write. No new
// request is taken until the result of the last one has been written.
// Reset clears the configuration registers, the sequencer and engine state, the energy sum and the output valid flag.
// The output register holds a finished result while the next request is taken and
// computed; only the final result write waits for the output to be free.
module pairwise_gravity_force (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // first_x, first_y, first_mass, second_x, second_y, second_mass
  input  logic [191:0]                s_axis_tdata_i,
  // clear_sum
  input  logic                        s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // force_x, force_y, potential_sum
  output logic [159:0]                m_axis_tdata_o,
  // coincident
  output logic                        m_axis_tuser_o,
  input  logic                        cfg_we_i,
  input  logic [pgf_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [31:0]                 cfg_wdata_i
);
  import pgf_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [47:0] force_x, force_y;
  logic [63:0] potential_sum;

  pgf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  pgf_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_data_i       (s_axis_tdata_i),
    .in_clear_i      (s_axis_tuser_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .force_x_o       (force_x),
    .force_y_o       (force_y),
    .potential_sum_o (potential_sum),
    .coincident_o    (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {potential_sum, force_y, force_x};

endmodule

>>> src/pgf_checker.sv
// Port-level checks for the pairwise gravity force block and their binding.
module pgf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [159:0] m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  // A request is worked on alone, so the input closes right after one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input still ready after a request was taken");

  // A new result appears only after the final step, when no input is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a finished computation");

  // Coincident points carry zero force.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[95:0] == 96'd0)
    else $error("coincident result with nonzero force");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind pairwise_gravity_force pgf_checker u_pgf_checker (.*);

>>> bench/tb_top.sv
// Self-checking testbench for the pairwise gravity force block, with a stream driver and monitor.
`timescale 1ns / 100ps

module tb_top;
  import pgf_pkg::*;

  typedef struct {
    logic signed [31:0] x1, y1;
    logic [31:0]        m1;
    logic signed [31:0] x2, y2;
    logic [31:0]        m2;
    logic               clr;
  } pair_t;

  typedef struct {
    logic [47:0] fx, fy;
    logic [63:0] sum;
    logic        coin;
  } force_t;

  localparam int unsigned WatchLimit = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [191:0] s_data = '0;
  logic s_user = 1'b0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [159:0] m_data;
  logic m_user;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr = REG_GRAV_MANT;
  logic [31:0] cfg_wdata = '0;

  pair_t  pending_pairs[$];
  force_t expected_forces[$];
  logic [31:0] grav_g;
  logic [5:0]  grav_s;
  logic [63:0] energy_acc;
  int errors, results, coin_seen, idle_cycles;
  bit took, hold_send, quiet;
  int send_gap, recv_gap;

  pairwise_gravity_force dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [47:0] sat_force(logic [127:0] mag, bit neg);
    logic [127:0] lim;
    logic [47:0] m;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    m = (mag > lim) ? lim[47:0] : mag[47:0];
    return neg ? -m : m;
  endfunction

  function automatic force_t predict_force(pair_t p);
    force_t f;
    longint dx, dy;
    logic [63:0] adx, ady, r, c, k;
    logic [127:0] sq, r3, gm, sh, q;
    f.fx = '0;
    f.fy = '0;
    f.coin = 1'b0;
    dx = longint'(p.x2) - longint'(p.x1);
    dy = longint'(p.y2) - longint'(p.y1);
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    sq = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
    if (p.clr) energy_acc = '0;
    if (sq == 0) begin
      f.coin = 1'b1;
    end else begin
      r = '0;
      for (int b = 32; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (sq >= 128'(c) * 128'(c)) r = c;
      end
      r3 = 128'(r) * 128'(r) * 128'(r);
      gm = 128'(grav_g) * 128'(p.m1) * 128'(p.m2);
      sh = gm >> grav_s;
      k = (sh[127:64] != 0) ? '1 : sh[63:0];
      f.fx = sat_force(((128'(k) * 128'(adx)) << 32) / r3, dx < 0);
      f.fy = sat_force(((128'(k) * 128'(ady)) << 32) / r3, dy < 0);
      q = (128'(k) << 16) / 128'(r);
      if (q > 128'(energy_acc ^ 64'h8000_0000_0000_0000))
        energy_acc = 64'h8000_0000_0000_0000;
      else energy_acc = energy_acc - q[63:0];
    end
    f.sum = energy_acc;
    return f;
  endfunction

  // Request side: acceptance and the idle watchdog are sampled here, the next request is driven at the falling edge.
  always @(posedge clk_i) begin
    if (s_valid && s_ready) begin
      expected_forces.push_back(predict_force(pending_pairs.pop_front()));
      took = 1'b1;
    end
    if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
    else if (rst_ni) idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("%0t timeout, %0d results outstanding", $realtime, expected_forces.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!s_valid || took) begin
      took = 1'b0;
      if (send_gap > 0) send_gap--;
      else if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 14);
      if (send_gap == 0 && !hold_send && pending_pairs.size() > 0) begin
        s_valid <= 1'b1;
        s_data <= {pending_pairs[0].m2, pending_pairs[0].y2, pending_pairs[0].x2,
                   pending_pairs[0].m1, pending_pairs[0].y1, pending_pairs[0].x1};
        s_user <= pending_pairs[0].clr;
      end else begin
        s_valid <= 1'b0;
      end
    end
    if (recv_gap > 0) begin
      recv_gap--;
      m_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      recv_gap = $urandom_range(1, 14);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (m_valid && m_ready) begin
      results++;
      if (expected_forces.size() == 0) begin
        $display("%0t unexpected result, actual %h coin %b", $realtime, m_data, m_user);
        errors++;
      end else begin
        force_t e;
        e = expected_forces.pop_front();
        if (e.coin) coin_seen++;
        if (m_data[47:0] !== e.fx) begin
          $display("%0t force_x expected %h actual %h", $realtime, e.fx, m_data[47:0]);
          errors++;
        end
        if (m_data[95:48] !== e.fy) begin
          $display("%0t force_y expected %h actual %h", $realtime, e.fy, m_data[95:48]);
          errors++;
        end
        if (m_data[159:96] !== e.sum) begin
          $display("%0t potential_sum expected %h actual %h", $realtime, e.sum,
                   m_data[159:96]);
          errors++;
        end
        if (m_user !== e.coin) begin
          $display("%0t coincident expected %b actual %b", $realtime, e.coin, m_user);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_GRAV_MANT) grav_g = val;
    else grav_s = val[5:0];
  endtask

  task automatic add_pair(logic [31:0] x1, logic [31:0] y1, logic [31:0] m1,
                          logic [31:0] x2, logic [31:0] y2, logic [31:0] m2, logic clr);
    pair_t p;
    p.x1 = x1; p.y1 = y1; p.m1 = m1;
    p.x2 = x2; p.y2 = y2; p.m2 = m2; p.clr = clr;
    pending_pairs.push_back(p);
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && expected_forces.size() == 0 && !s_valid);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_pairs(int n);
    logic [31:0] x, y, span;
    for (int i = 0; i < n; i++) begin
      x = $urandom;
      y = $urandom;
      case ($urandom_range(0, 3))
        0: span = $urandom_range(0, 32'hfffffffe);
        1: span = $urandom_range(0, 32'h3ffff);
        2: span = $urandom_range(0, 3);
        default: span = $urandom_range(0, 32'hffffff);
      endcase
      add_pair(x, y, $urandom, x + ($urandom % (span + 1)) - (span >> 1),
               y + ($urandom % (span + 1)) - (span >> 1), $urandom,
               $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    grav_g = '0;
    grav_s = '0;
    energy_acc = '0;
    errors = 0;
    results = 0;
    coin_seen = 0;
    idle_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_send = 1'b0;
    quiet = 1'b0;
    took = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_GRAV_MANT, 32'd1 << 16);
    write_reg(REG_GRAV_SHIFT, 32'd16);
    add_pair(32'h7fffffff, 32'h7fffffff, '1, 32'h80000000, 32'h80000000, '1, 1'b1);
    add_pair(32'h80000000, 32'h0, 32'd256, 32'h7fffffff, 32'h0, 32'd256, 1'b0);
    add_pair(32'h10000, 32'h20000, 32'd256, 32'h10000, 32'h20000, 32'd512, 1'b0);
    add_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 1'b0);
    add_pair(32'h0, 32'h0, 32'h100, 32'h10000, 32'h0, 32'h100, 1'b1);
    add_pair(32'h0, 32'h0, '1, 32'h1, 32'h1, '1, 1'b0);
    add_pair(32'h5, 32'h5, '1, 32'h4, 32'h4, '1, 1'b0);
    add_pair(32'hffff0000, 32'h30000, 32'h12345, 32'h20000, 32'hfffd0000, 32'h777, 1'b0);
    drain();

    write_reg(REG_GRAV_MANT, '1);
    write_reg(REG_GRAV_SHIFT, 32'd0);
    add_pair(32'h0, 32'h0, '1, 32'h1, 32'h0, '1, 1'b1);
    add_pair(32'h0, 32'h0, '1, 32'h0, 32'h1, '1, 1'b0);
    add_pair(32'h0, 32'h0, '1, 32'h0, 32'h0, '1, 1'b0);
    add_pair(32'h0, 32'h0, '1, 32'h1, 32'h0, '1, 1'b1);
    add_pair(32'h80000000, 32'h7fffffff, '1, 32'h7fffffff, 32'h80000000, '1, 1'b0);
    drain();

    write_reg(REG_GRAV_MANT, '0);
    write_reg(REG_GRAV_SHIFT, 32'd63);
    add_pair(32'h0, 32'h0, '1, 32'h10000, 32'h10000, '1, 1'b1);
    add_pair(32'h1, 32'h0, '1, 32'h0, 32'h0, '1, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_GRAV_MANT, (ph == 0) ? '1 : $urandom);
      write_reg(REG_GRAV_SHIFT, (ph == 1) ? 32'd63 : $urandom);
      if (ph == 5) quiet = 1'b1;
      random_pairs(50);
      if (ph == 2) begin
        wait (pending_pairs.size() <= 25);
        hold_send = 1'b1;
        wait (expected_forces.size() == 0 && !s_valid);
        repeat (5) @(posedge clk_i);
        hold_send = 1'b0;
      end
      random_pairs(50);
      drain();
    end

    $display("Covered %0d results, %0d of them coincident, over nine register settings",
             results, coin_seen);
    $display("including saturated constant, extreme coordinates and a full sender pause.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
src/pgf_pkg.sv
src/pgf_ctrl.sv
src/pgf_datapath.sv
src/pairwise_gravity_force.sv
src/pgf_checker.sv
bench/tb_top.sv
